// ----- rtl/core/u16u8_pkg.sv -----
// Shared types, constants and the UTF-8 length and byte selection functions of the transcoder.
package u16u8_pkg;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_unit;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       stream_end;
	} result_t;

	// One command from the front to the back: an optional replacement character
	// followed by an optional code point, together with the stream end mark.
	typedef struct packed {
		logic        has_fffd;
		logic        has_cp;
		logic [20:0] cp;
		logic [1:0]  cp_len_m1;
		logic        last;
	} cmd_t;

	localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
	localparam logic [20:0] SUPP_BASE     = 21'h10000;
	localparam logic [20:0] REPLACEMENT   = 21'h0fffd;
	localparam logic [20:0] LIM_ONE       = 21'h00080;
	localparam logic [20:0] LIM_TWO       = 21'h00800;
	localparam logic [20:0] LIM_THREE     = 21'h10000;
	localparam logic [7:0]  FFFD_B0       = 8'hef;
	localparam logic [7:0]  FFFD_B1       = 8'hbf;
	localparam logic [7:0]  FFFD_B2       = 8'hbd;

	localparam logic [1:0] LEN_ONE   = 2'd0;
	localparam logic [1:0] LEN_TWO   = 2'd1;
	localparam logic [1:0] LEN_THREE = 2'd2;
	localparam logic [1:0] LEN_FOUR  = 2'd3;

	function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
		logic [1:0] len;
		if (cp < LIM_ONE) begin
			len = LEN_ONE;
		end else if (cp < LIM_TWO) begin
			len = LEN_TWO;
		end else if (cp < LIM_THREE) begin
			len = LEN_THREE;
		end else begin
			len = LEN_FOUR;
		end
		return len;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len_m1,
		input logic [1:0] idx);
		logic [7:0] b;
		b = {2'b10, cp[5:0]};
		unique case (len_m1)
			LEN_ONE: b = {1'b0, cp[6:0]};
			LEN_TWO: begin
				if (idx == 2'd0) b = {3'b110, cp[10:6]};
			end
			LEN_THREE: begin
				if (idx == 2'd0) b = {4'b1110, cp[15:12]};
				else if (idx == 2'd1) b = {2'b10, cp[11:6]};
			end
			LEN_FOUR: begin
				if (idx == 2'd0) b = {5'b11110, cp[20:18]};
				else if (idx == 2'd1) b = {2'b10, cp[17:12]};
				else if (idx == 2'd2) b = {2'b10, cp[11:6]};
			end
			default: b = {2'b10, cp[5:0]};
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/core/u16u8_front.sv -----
// Front part: accepts code units, tracks a held high surrogate and builds commands.
module u16u8_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  u16u8_pkg::item_t     item,
	output logic                 cmd_push,
	output u16u8_pkg::cmd_t      cmd
);
	import u16u8_pkg::*;

	logic       high_pending_q;
	logic [9:0] held_high_bits_q;
	logic       is_high;
	logic       is_low;
	logic       pending_d;
	logic [20:0] cp;

	assign is_high = item.code_unit[15:10] == HIGH_SURR_TAG;
	assign is_low  = item.code_unit[15:10] == LOW_SURR_TAG;

	always_comb begin
		cmd.has_fffd = 1'b0;
		cmd.has_cp   = 1'b1;
		cp           = {5'd0, item.code_unit};
		pending_d    = 1'b0;
		if (high_pending_q && is_low) begin
			cp = SUPP_BASE + {1'b0, held_high_bits_q, item.code_unit[9:0]};
		end else begin
			cmd.has_fffd = high_pending_q;
			if (is_high) begin
				if (item.last_unit) begin
					cp = REPLACEMENT;
				end else begin
					cmd.has_cp = 1'b0;
					pending_d  = 1'b1;
				end
			end else if (is_low) begin
				cp = REPLACEMENT;
			end
		end
		cmd.cp        = cp;
		cmd.cp_len_m1 = utf8_len_m1(cp);
		cmd.last      = item.last_unit;
	end

	assign cmd_push = accept && (cmd.has_fffd || cmd.has_cp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_pending_q <= 1'b0;
		end else if (accept) begin
			high_pending_q <= pending_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_high) begin
			held_high_bits_q <= item.code_unit[9:0];
		end
	end

endmodule

// ----- rtl/core/u16u8_fifo.sv -----
// Short command queue between the front and the back.
module u16u8_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  u16u8_pkg::cmd_t      wdata,
	output logic                 full,
	input  logic                 pop,
	output logic                 nonempty,
	output u16u8_pkg::cmd_t      rdata
);
	import u16u8_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cmd_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = count_q == FULL_CNT;
	assign nonempty = count_q != '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign rdata    = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- rtl/core/u16u8_back.sv -----
// Back part: expands one command into UTF-8 bytes into an output register.
module u16u8_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_avail,
	input  u16u8_pkg::cmd_t      cmd,
	output logic                 cmd_take,
	output logic                 empty,
	input  logic                 pop,
	output u16u8_pkg::result_t   result
);
	import u16u8_pkg::*;

	cmd_t       cur_q;
	logic       cur_valid_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	result_t    out_q;
	logic [2:0] total;
	logic [2:0] local_idx;
	logic       final_byte;
	logic       emit;
	logic [7:0] byte_val;

	always_comb begin
		total = (cur_q.has_fffd ? 3'd3 : 3'd0)
			+ (cur_q.has_cp ? {1'b0, cur_q.cp_len_m1} + 3'd1 : 3'd0);
		local_idx = cur_q.has_fffd ? idx_q - 3'd3 : idx_q;
		if (cur_q.has_fffd && idx_q < 3'd3) begin
			unique case (idx_q[1:0])
				2'd0:    byte_val = FFFD_B0;
				2'd1:    byte_val = FFFD_B1;
				default: byte_val = FFFD_B2;
			endcase
		end else begin
			byte_val = utf8_byte(cur_q.cp, cur_q.cp_len_m1, local_idx[1:0]);
		end
	end

	assign final_byte = idx_q == total - 3'd1;
	assign emit       = cur_valid_q && (!out_valid_q || pop);
	assign cmd_take   = cmd_avail && (!cur_valid_q || (emit && final_byte));
	assign empty      = !out_valid_q;
	assign result     = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (emit) begin
				if (final_byte) begin
					cur_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cur_q <= cmd;
		end
		if (emit) begin
			out_q.out_byte   <= byte_val;
			out_q.run_last   <= final_byte;
			out_q.stream_end <= final_byte && cur_q.last;
		end
	end

endmodule

// ----- rtl/core/utf16le_to_utf8_transcoder.sv -----
// Top level of the UTF-16LE to UTF-8 transcoder.
// Each command passes the queue, the back part's command register and then the result register.
// Throughput: one output byte per cycle while the result is popped, set by the byte-wide result
// register of the back part; a unit yields one to six bytes, three for most BMP text.
// A unit that yields no bytes (a held high surrogate) occupies only the front and pushes no command.
// Reset is asynchronous and clears the held surrogate, the queue and the output register.
module utf16le_to_utf8_transcoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  u16u8_pkg::item_t     item,
	output logic                 empty,
	input  logic                 pop,
	output u16u8_pkg::result_t   result
);
	import u16u8_pkg::*;

	logic cmd_push;
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_avail;
	logic cmd_take;
	logic accept;

	assign accept = push && !full;

	u16u8_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	u16u8_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.wdata    (cmd_in),
		.full     (full),
		.pop      (cmd_take),
		.nonempty (cmd_avail),
		.rdata    (cmd_out)
	);

	u16u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (cmd_avail),
		.cmd       (cmd_out),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ----- tb/sv/utf8_stream_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts the UTF-8 bytes of each accepted code unit and compares the popped beats.
module utf8_stream_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  u16u8_pkg::item_t     item,
	input  logic                 empty,
	input  logic                 pop,
	input  u16u8_pkg::result_t   result,
	output int unsigned          fail_count,
	output int unsigned          bytes_owed
);
	import u16u8_pkg::*;

	localparam logic [20:0] REPLACEMENT_CHAR = 21'h0fffd;
	localparam logic [20:0] PLANE_ONE_BASE   = 21'h10000;

	result_t     utf8_bytes_due[$];
	result_t     want;
	logic        high_held = 1'b0;
	logic [9:0]  high_bits = '0;
	int unsigned mismatches = 0;

	task automatic append_byte(input logic [7:0] b);
		utf8_bytes_due.insert(utf8_bytes_due.size(),
			result_t'{out_byte: b, run_last: 1'b0, stream_end: 1'b0});
	endtask

	task automatic append_code_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			append_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			append_byte(8'hc0 | {3'b000, cp[10:6]});
			append_byte(8'h80 | {2'b00, cp[5:0]});
		end else if (cp < 21'h10000) begin
			append_byte(8'he0 | {4'b0000, cp[15:12]});
			append_byte(8'h80 | {2'b00, cp[11:6]});
			append_byte(8'h80 | {2'b00, cp[5:0]});
		end else begin
			append_byte(8'hf0 | {5'b00000, cp[20:18]});
			append_byte(8'h80 | {2'b00, cp[17:12]});
			append_byte(8'h80 | {2'b00, cp[11:6]});
			append_byte(8'h80 | {2'b00, cp[5:0]});
		end
	endtask

	task automatic transcode_unit(input item_t it);
		int unsigned first;
		logic        is_high;
		logic        is_low;
		result_t     tail;
		first = utf8_bytes_due.size();
		is_high = it.code_unit[15:10] == HIGH_SURR_TAG;
		is_low = it.code_unit[15:10] == LOW_SURR_TAG;
		if (high_held && is_low) begin
			append_code_point(PLANE_ONE_BASE + {1'b0, high_bits, it.code_unit[9:0]});
			high_held = 1'b0;
			high_bits = '0;
		end else begin
			if (high_held) begin
				append_code_point(REPLACEMENT_CHAR);
				high_held = 1'b0;
				high_bits = '0;
			end
			if (is_high) begin
				high_held = 1'b1;
				high_bits = it.code_unit[9:0];
			end else if (is_low) begin
				append_code_point(REPLACEMENT_CHAR);
			end else begin
				append_code_point({5'b00000, it.code_unit});
			end
		end
		if (it.last_unit && high_held) begin
			append_code_point(REPLACEMENT_CHAR);
			high_held = 1'b0;
			high_bits = '0;
		end
		if (utf8_bytes_due.size() > first) begin
			tail = utf8_bytes_due.pop_back();
			tail.run_last = 1'b1;
			tail.stream_end = it.last_unit;
			utf8_bytes_due.insert(utf8_bytes_due.size(), tail);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_held = 1'b0;
			high_bits = '0;
			utf8_bytes_due.delete();
		end else begin
			if (push && !full) begin
				transcode_unit(item);
			end
			if (pop && !empty) begin
				if (utf8_bytes_due.size() == 0) begin
					$error("out_byte: expected none, actual %h", result.out_byte);
					mismatches++;
				end else begin
					want = utf8_bytes_due.pop_front();
					if (result.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, actual %h", want.out_byte, result.out_byte);
						mismatches++;
					end
					if (result.run_last !== want.run_last) begin
						$error("run_last: expected %b, actual %b", want.run_last, result.run_last);
						mismatches++;
					end
					if (result.stream_end !== want.stream_end) begin
						$error("stream_end: expected %b, actual %b", want.stream_end,
							result.stream_end);
						mismatches++;
					end
				end
			end
		end
		bytes_owed <= utf8_bytes_due.size();
		fail_count <= mismatches;
	end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Top of the transcoder testbench: clock, reset, code unit stimulus and the verdict.
module testbench;
	import u16u8_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned UNIT_TOTAL  = 245;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	item_t       item = '0;
	logic        empty;
	logic        pop = 1'b0;
	result_t     result;
	logic        steady = 1'b0;
	int unsigned fail_count;
	int unsigned bytes_owed;
	int unsigned cycle_count = 0;
	int unsigned units_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	utf16le_to_utf8_transcoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	utf8_stream_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.fail_count (fail_count),
		.bytes_owed (bytes_owed)
	);

	always @(posedge clk) begin
		pop <= steady || ($urandom_range(99) >= 11);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** utf16le_to_utf8_transcoder: FAILED **");
			$finish;
		end
	end

	task automatic send_unit(input logic [15:0] unit, input logic last);
		push <= 1'b1;
		item <= item_t'{code_unit: unit, last_unit: last};
		@(posedge clk);
		while (full) @(posedge clk);
		units_sent++;
		if (!steady && $urandom_range(99) < 11) begin
			push <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (bytes_owed != 0) @(posedge clk);
	endtask

	task automatic send_random_char(input logic last);
		logic [15:0] unit;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 35) begin
			unit = 16'($urandom_range(16'h007f));
		end else if (pick < 52) begin
			unit = 16'($urandom_range(16'h07ff, 16'h0080));
		end else if (pick < 70) begin
			do unit = 16'($urandom_range(16'hffff, 16'h0800));
			while (unit[15:11] == HIGH_SURR_TAG[5:1]);
		end else if (pick < 88) begin
			send_unit({HIGH_SURR_TAG, 10'($urandom)}, 1'b0);
			unit = {LOW_SURR_TAG, 10'($urandom)};
		end else if (pick < 94) begin
			unit = {HIGH_SURR_TAG[5:1], 11'($urandom)};
		end else begin
			unit = 16'($urandom);
		end
		send_unit(unit, last);
	endtask

	initial begin
		int unsigned chars;
		logic        drained_once;
		drained_once = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_unit(16'h0000, 1'b0);
		send_unit(16'h007f, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07ff, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hffff, 1'b0);
		send_unit(16'he000, 1'b0);
		send_unit(16'hd800, 1'b0);
		send_unit(16'hdc00, 1'b0);
		send_unit(16'hdbff, 1'b0);
		send_unit(16'hdfff, 1'b0);
		send_unit(16'hdc00, 1'b0);
		send_unit(16'hdfff, 1'b0);
		send_unit(16'hd800, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'hd800, 1'b0);
		send_unit(16'hffff, 1'b0);
		send_unit(16'hdbff, 1'b0);
		send_unit(16'hd800, 1'b0);
		send_unit(16'hdc00, 1'b0);
		send_unit(16'hdbff, 1'b1);
		send_unit(16'hd800, 1'b0);
		send_unit(16'h0041, 1'b1);
		send_unit(16'hd83d, 1'b0);
		send_unit(16'hde00, 1'b1);
		send_unit(16'hdc00, 1'b1);

		while (units_sent < UNIT_TOTAL) begin
			steady <= units_sent >= 100 && units_sent < 160;
			if (!drained_once && units_sent >= 180) begin
				wait_drained();
				drained_once = 1'b1;
			end
			chars = $urandom_range(12, 1);
			for (int unsigned i = 1; i <= chars; i++) begin
				send_random_char(i == chars);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("** utf16le_to_utf8_transcoder: PASSED **");
		end else begin
			$display("** utf16le_to_utf8_transcoder: FAILED **");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/u16u8_pkg.sv
rtl/core/u16u8_front.sv
rtl/core/u16u8_fifo.sv
rtl/core/u16u8_back.sv
rtl/core/utf16le_to_utf8_transcoder.sv
tb/sv/utf8_stream_checker.sv
tb/sv/testbench.sv
